// ----- rtl/ftt_pkg.sv -----
// Shared types, constants and state rules of the flow table tracker.
package ftt_pkg;

  // Table geometry: buckets and ways are powers of two.
  localparam int BUCKET_BITS = 8;
  localparam int BUCKETS     = 1 << BUCKET_BITS;
  localparam int WAY_BITS    = 2;
  localparam int WAYS        = 1 << WAY_BITS;
  localparam int ENTRY_BITS  = BUCKET_BITS + WAY_BITS;
  localparam int ENTRIES     = 1 << ENTRY_BITS;

  // Item kinds and protocol classes.
  localparam logic       ACT_SWEEP  = 1'b1;
  localparam logic [1:0] PR_ICMP    = 2'd0;
  localparam logic [1:0] PR_UDP     = 2'd1;
  localparam logic [1:0] PR_TCP     = 2'd2;
  localparam logic [1:0] PR_OTHER   = 2'd3;

  // Bit positions in the TCP flag byte.
  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_RST = 2;
  localparam int FLAG_ACK = 4;

  // Connection states.
  localparam logic [3:0] CS_NONE       = 4'd0;
  localparam logic [3:0] CS_SYN        = 4'd1;
  localparam logic [3:0] CS_SYNACK     = 4'd2;
  localparam logic [3:0] CS_ACK        = 4'd3;
  localparam logic [3:0] CS_RST        = 4'd4;
  localparam logic [3:0] CS_HALF_OPEN  = 4'd5;
  localparam logic [3:0] CS_FIN        = 4'd6;
  localparam logic [3:0] CS_FIN2       = 4'd7;
  localparam logic [3:0] CS_OVERCLOSE  = 4'd8;
  localparam logic [3:0] CS_BLINDSPOOF = 4'd9;
  localparam logic [3:0] CS_PARTIAL    = 4'd10;
  localparam logic [3:0] CS_UDP_OPEN   = 4'd11;
  localparam logic [3:0] CS_UDP_ESTA   = 4'd12;

  // Result status codes.
  localparam logic [1:0] ST_NEW     = 2'd0;
  localparam logic [1:0] ST_CONT    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_UNICAST   = 1'b0;
  localparam logic CFG_BROADCAST = 1'b1;

  typedef struct packed {
    logic        action;
    logic [1:0]  proto_class;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  tcp_flags;
    logic [15:0] pkt_len;
    logic [31:0] time_sec;
    logic        is_broadcast;
    logic [7:0]  sanity_bits;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] session_number;
    logic [3:0]  conn_state;
    logic        from_client;
    logic [31:0] pkts_out_before;
    logic [31:0] pkts_in_before;
    logic [31:0] last_seen_before;
    logic [10:0] removed_count;
  } result_t;

  // Classified item handed from the front end to the table engine.
  typedef struct packed {
    logic                   sweep;
    logic                   ignore;
    logic                   syn_only;
    logic [1:0]             proto;
    logic [31:0]            src;
    logic [31:0]            dst;
    logic [15:0]            sport;
    logic [15:0]            dport;
    logic [7:0]             flags;
    logic [31:0]            now;
    logic                   bcast;
    logic [7:0]             san;
    logic [BUCKET_BITS-1:0] bucket;
  } cls_t;

  // One session entry of the table.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [1:0]  proto;
    logic [3:0]  cstate;
    logic [31:0] last;
    logic [31:0] cnt_out;
    logic [31:0] cnt_in;
    logic        bcast;
    logic [7:0]  san;
    logic [31:0] id;
  } entry_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_ROW,
    B_ROWW,
    B_PRD,
    B_PCHK,
    B_HIT,
    B_INS,
    B_SW_ROW,
    B_SW_RD,
    B_SW_CHK,
    B_SW_WR
  } back_state_t;

  // TCP state transition for a packet that hits an existing session.
  function automatic logic [3:0] tcp_next(input logic [7:0] f, input logic [3:0] s);
    logic fin;
    logic syn;
    logic rst;
    logic ack;
    logic [3:0] r;
    fin = f[FLAG_FIN];
    syn = f[FLAG_SYN];
    rst = f[FLAG_RST];
    ack = f[FLAG_ACK];
    if (ack && s == CS_SYNACK) r = CS_ACK;
    else if (ack && s == CS_ACK) r = CS_ACK;
    else if (syn && ack) r = CS_SYNACK;
    else if (rst && s == CS_ACK) r = CS_RST;
    else if (rst && s == CS_SYNACK) r = CS_HALF_OPEN;
    else if (fin && s == CS_ACK) r = CS_FIN;
    else if (fin && s == CS_FIN) r = CS_FIN2;
    else if ((fin || rst) && (s == CS_FIN2 || s == CS_RST)) r = CS_OVERCLOSE;
    else if (ack && !syn && s == CS_SYN) r = CS_BLINDSPOOF;
    else r = CS_PARTIAL;
    return r;
  endfunction

endpackage

// ----- rtl/ftt_front.sv -----
// Front end: accepts items, computes the bucket hash and classifies them.
module ftt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  ftt_pkg::item_t item,
  input  logic          hold,
  output logic          q_push,
  output ftt_pkg::cls_t q_data,
  input  logic          q_full
);
  import ftt_pkg::*;

  logic        s0_v;
  item_t       s0;
  logic        s1_v;
  cls_t        s1;
  logic [31:0] s1_prod;
  logic [16:0] s1_sum;

  logic        take;
  logic        adv1;
  logic [15:0] sp;
  logic [15:0] dp;
  logic [31:0] prod;
  logic [16:0] sum;
  cls_t        s0c;
  logic [31:0] key;

  // Multiply by the protocol class, which is at most three.
  function automatic logic [31:0] mul_class(input logic [31:0] x, input logic [1:0] p);
    logic [31:0] a;
    logic [31:0] b;
    a = p[0] ? x : 32'd0;
    b = p[1] ? {x[30:0], 1'b0} : 32'd0;
    return a + b;
  endfunction

  // Handshake and stall control of the two stages.
  assign adv1   = !s1_v || !q_full;
  assign q_push = s1_v && !q_full;
  assign full   = hold || (s0_v && !adv1);
  assign take   = push && !full;

  // Stage 0: ports are zero for icmp; the port product gets its own register.
  always_comb begin
    sp           = (s0.proto_class == PR_ICMP) ? 16'd0 : s0.src_port;
    dp           = (s0.proto_class == PR_ICMP) ? 16'd0 : s0.dst_port;
    prod         = sp * dp;
    sum          = {1'b0, sp} + {1'b0, dp};
    s0c.sweep    = (s0.action == ACT_SWEEP);
    s0c.ignore   = (s0.action != ACT_SWEEP) && (s0.proto_class == PR_OTHER);
    s0c.syn_only = (s0.proto_class == PR_TCP) && s0.tcp_flags[FLAG_SYN] &&
                   !s0.tcp_flags[FLAG_ACK];
    s0c.proto    = s0.proto_class;
    s0c.src      = s0.src_addr;
    s0c.dst      = s0.dst_addr;
    s0c.sport    = sp;
    s0c.dport    = dp;
    s0c.flags    = s0.tcp_flags;
    s0c.now      = s0.time_sec;
    s0c.bcast    = s0.is_broadcast;
    s0c.san      = s0.sanity_bits;
    s0c.bucket   = '0;
  end

  // Stage 1: the key is symmetric in the endpoints, so the reverse bucket
  // always equals the forward bucket.
  always_comb begin
    key = {16'd0, s1.src[31:16]} + {16'd0, s1.dst[31:16]} +
          mul_class(s1_prod, s1.proto) + mul_class({15'd0, s1_sum}, s1.proto);
    q_data        = s1;
    q_data.bucket = key[BUCKET_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
    end else begin
      s0_v <= take || (s0_v && !adv1);
      if (adv1) begin
        s1_v <= s0_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s0 <= item;
    end
    if (adv1) begin
      s1      <= s0c;
      s1_prod <= prod;
      s1_sum  <= sum;
    end
  end

endmodule

// ----- rtl/ftt_queue.sv -----
// Two-entry queue of classified items between front end and table engine.
module ftt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  ftt_pkg::cls_t wr_data,
  output logic          q_full,
  input  logic          rd,
  output ftt_pkg::cls_t rd_data,
  output logic          q_empty
);
  import ftt_pkg::*;

  cls_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign q_full  = (cnt == 2'd2);
  assign q_empty = (cnt == 2'd0);
  assign rd_data = slots[rp];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      if (wr && !rd) cnt <= cnt + 2'd1;
      else if (rd && !wr) cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wp] <= wr_data;
    end
  end

endmodule

// ----- rtl/ftt_back.sv -----
// Table engine: bucket probe, session update or insert, aging sweep, results.
module ftt_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  output logic            q_pop,
  input  ftt_pkg::cls_t   q_data,
  input  logic            cfg_we,
  input  logic            cfg_idx,
  input  logic [31:0]     cfg_data,
  output logic            clearing,
  output logic            empty,
  input  logic            pop,
  output ftt_pkg::result_t result
);
  import ftt_pkg::*;

  // Table memories: a valid row per bucket and the entries themselves.
  logic [WAYS-1:0] valid_mem [BUCKETS];
  entry_t          entry_mem [ENTRIES];

  back_state_t            state;
  back_state_t            state_next;
  cls_t                   cur;
  logic [WAY_BITS-1:0]    way;
  logic [WAYS-1:0]        row;
  logic [BUCKET_BITS-1:0] clr;
  logic [BUCKET_BITS-1:0] sw_b;
  logic [10:0]            removed;
  logic [31:0]            sess;
  logic [31:0]            uto;
  logic [31:0]            bto;

  // Memory ports.
  logic                   v_we;
  logic [BUCKET_BITS-1:0] v_waddr;
  logic [WAYS-1:0]        v_wdata;
  logic                   v_re;
  logic [BUCKET_BITS-1:0] v_raddr;
  logic [WAYS-1:0]        v_rd;
  logic                   e_we;
  logic [ENTRY_BITS-1:0]  e_waddr;
  entry_t                 e_wdata;
  logic                   e_re;
  logic [ENTRY_BITS-1:0]  e_raddr;
  entry_t                 e_rd;

  // Result queue.
  result_t    ofifo [2];
  logic       o_wp;
  logic       o_rp;
  logic [1:0] ocnt;
  logic       res_push;
  result_t    res;
  logic       o_pop;

  // Probe and update datapath.
  logic            last_way;
  logic [31:0]     limit;
  logic [31:0]     elapsed;
  logic            match;
  logic            fwd;
  logic [3:0]      ns;
  logic [WAYS-1:0] free_hot;
  logic            free_any;
  logic [WAY_BITS-1:0] free_way;
  logic [3:0]      ins_state;
  logic            expired;

  assign clearing = (state == B_CLEAR);
  assign empty    = (ocnt == 2'd0);
  assign result   = ofifo[o_rp];
  assign o_pop    = pop && !empty;
  assign last_way = (way == WAY_BITS'(WAYS - 1));

  // Match test on the entry just read.
  always_comb begin
    limit   = e_rd.bcast ? bto : uto;
    elapsed = cur.now - e_rd.last;
    match   = row[way] && !(elapsed > limit) && (e_rd.proto == cur.proto) &&
              ((e_rd.src == cur.src && e_rd.dst == cur.dst &&
                e_rd.sport == cur.sport && e_rd.dport == cur.dport) ||
               (e_rd.src == cur.dst && e_rd.dst == cur.src &&
                e_rd.sport == cur.dport && e_rd.dport == cur.sport));
    fwd     = (e_rd.src == cur.src);
    if (cur.proto == PR_TCP) ns = tcp_next(cur.flags, e_rd.cstate);
    else ns = fwd ? e_rd.cstate : CS_UDP_ESTA;
    expired = (cur.now - e_rd.last) > uto;
  end

  // First free way of the probed bucket, and the state of a new session.
  always_comb begin
    free_hot = '0;
    free_any = 1'b0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!row[w] && !free_any) begin
        free_any    = 1'b1;
        free_way    = WAY_BITS'(w);
        free_hot[w] = 1'b1;
      end
    end
    case (cur.proto)
      PR_TCP:  ins_state = cur.syn_only ? CS_SYN : CS_PARTIAL;
      PR_UDP:  ins_state = CS_UDP_OPEN;
      default: ins_state = CS_NONE;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR:  if (clr == '1) state_next = B_IDLE;
      B_IDLE: begin
        if (q_pop && q_data.sweep) state_next = B_SW_ROW;
        else if (q_pop && !q_data.ignore) state_next = B_ROW;
      end
      B_ROW:    state_next = B_ROWW;
      B_ROWW:   state_next = cur.syn_only ? B_INS : B_PRD;
      B_PRD:    state_next = B_PCHK;
      B_PCHK: begin
        if (match) state_next = B_HIT;
        else if (last_way) state_next = B_INS;
        else state_next = B_PRD;
      end
      B_HIT:    state_next = B_IDLE;
      B_INS:    state_next = B_IDLE;
      B_SW_ROW: state_next = B_SW_RD;
      B_SW_RD:  state_next = B_SW_CHK;
      B_SW_CHK: state_next = last_way ? B_SW_WR : B_SW_RD;
      B_SW_WR:  state_next = (sw_b == '1) ? B_IDLE : B_SW_ROW;
      default:  state_next = B_IDLE;
    endcase
  end

  // Memory controls and result generation.
  always_comb begin
    q_pop    = 1'b0;
    v_we     = 1'b0;
    v_waddr  = cur.bucket;
    v_wdata  = row;
    v_re     = 1'b0;
    v_raddr  = cur.bucket;
    e_we     = 1'b0;
    e_waddr  = {cur.bucket, way};
    e_wdata  = e_rd;
    e_re     = 1'b0;
    e_raddr  = {cur.bucket, way};
    res_push = 1'b0;
    res      = '0;
    unique case (state)
      B_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = clr;
        v_wdata = '0;
      end
      B_IDLE: begin
        q_pop = !q_empty && (ocnt != 2'd2);
        if (q_pop && q_data.ignore) begin
          res_push   = 1'b1;
          res.status = ST_IGNORED;
        end
      end
      B_ROW: v_re = 1'b1;
      B_PRD: e_re = 1'b1;
      B_HIT: begin
        e_we           = 1'b1;
        e_wdata.cstate = ns;
        e_wdata.last   = cur.now;
        e_wdata.san    = e_rd.san | cur.san;
        if (fwd) e_wdata.cnt_out = e_rd.cnt_out + 32'd1;
        else e_wdata.cnt_in = e_rd.cnt_in + 32'd1;
        res_push             = 1'b1;
        res.status           = ST_CONT;
        res.session_number   = e_rd.id;
        res.conn_state       = ns;
        res.from_client      = fwd;
        res.pkts_out_before  = e_rd.cnt_out;
        res.pkts_in_before   = e_rd.cnt_in;
        res.last_seen_before = e_rd.last;
      end
      B_INS: begin
        res_push = 1'b1;
        if (free_any) begin
          e_we            = 1'b1;
          e_waddr         = {cur.bucket, free_way};
          e_wdata.src     = cur.src;
          e_wdata.dst     = cur.dst;
          e_wdata.sport   = cur.sport;
          e_wdata.dport   = cur.dport;
          e_wdata.proto   = cur.proto;
          e_wdata.cstate  = ins_state;
          e_wdata.last    = cur.now;
          e_wdata.cnt_out = 32'd1;
          e_wdata.cnt_in  = 32'd0;
          e_wdata.bcast   = cur.bcast;
          e_wdata.san     = cur.san;
          e_wdata.id      = sess + 32'd1;
          v_we            = 1'b1;
          v_wdata         = row | free_hot;
          res.status      = (ins_state == CS_PARTIAL) ? ST_CONT : ST_NEW;
          res.session_number = sess + 32'd1;
          res.conn_state  = ins_state;
          res.from_client = 1'b1;
        end else begin
          res.status = ST_FULL;
        end
      end
      B_SW_ROW: begin
        v_re    = 1'b1;
        v_raddr = sw_b;
      end
      B_SW_RD: begin
        e_re    = 1'b1;
        e_raddr = {sw_b, way};
      end
      B_SW_CHK: begin
        e_waddr         = {sw_b, way};
        e_wdata.cnt_out = 32'd0;
        e_wdata.cnt_in  = 32'd0;
        e_we            = row[way] && !expired;
      end
      B_SW_WR: begin
        v_we    = 1'b1;
        v_waddr = sw_b;
        if (sw_b == '1) begin
          res_push          = 1'b1;
          res.status        = ST_IGNORED;
          res.removed_count = removed;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      clr   <= '0;
      sess  <= 32'd0;
      uto   <= 32'd300;
      bto   <= 32'd60;
      o_wp  <= 1'b0;
      o_rp  <= 1'b0;
      ocnt  <= 2'd0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) clr <= clr + 1'b1;
      if (state == B_INS && free_any) sess <= sess + 32'd1;
      if (cfg_we) begin
        if (cfg_idx == CFG_UNICAST) uto <= cfg_data;
        else bto <= cfg_data;
      end
      if (res_push) o_wp <= !o_wp;
      if (o_pop) o_rp <= !o_rp;
      if (res_push && !o_pop) ocnt <= ocnt + 2'd1;
      else if (o_pop && !res_push) ocnt <= ocnt - 2'd1;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_pop) cur <= q_data;
        sw_b    <= '0;
        removed <= 11'd0;
      end
      B_ROWW: begin
        row <= v_rd;
        way <= '0;
      end
      B_PCHK: if (!match) way <= way + 1'b1;
      B_SW_ROW: way <= '0;
      B_SW_RD: if (way == '0) row <= v_rd;
      B_SW_CHK: begin
        if (row[way] && expired) begin
          row[way] <= 1'b0;
          removed  <= removed + 11'd1;
        end
        way <= way + 1'b1;
      end
      B_SW_WR: sw_b <= sw_b + 1'b1;
      default: ;
    endcase
    if (res_push) ofifo[o_wp] <= res;
  end

  // Memory arrays with registered reads.
  always_ff @(posedge clk) begin
    if (v_we) valid_mem[v_waddr] <= v_wdata;
    if (v_re) v_rd <= valid_mem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (e_we) entry_mem[e_waddr] <= e_wdata;
    if (e_re) e_rd <= entry_mem[e_raddr];
  end

endmodule

// ----- rtl/flow_table_tcp_state_tracker_top.sv -----
// A packet passes front-end stages 0 and 1 and the queue before the engine probes its bucket.
// A packet reads one valid row and up to WAYS entries; each entry read takes states B_PRD and B_PCHK.
// The engine takes a new packet from the queue only in its idle state, once the last one is done.
// A sweep walks every bucket, reading its valid row and entries and writing the row back.
// After synchronous reset, a clearing pass over every bucket holds full high.
module flow_table_tcp_state_tracker_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  ftt_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output ftt_pkg::result_t result,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [31:0]      cfg_data
);
  import ftt_pkg::*;

  logic clearing;
  logic fq_push;
  cls_t fq_wdata;
  logic fq_full;
  logic fq_pop;
  cls_t fq_rdata;
  logic fq_empty;

  // Hash and classify.
  ftt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .hold   (clearing),
    .q_push (fq_push),
    .q_data (fq_wdata),
    .q_full (fq_full)
  );

  // Decoupling queue.
  ftt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (fq_push),
    .wr_data (fq_wdata),
    .q_full  (fq_full),
    .rd      (fq_pop),
    .rd_data (fq_rdata),
    .q_empty (fq_empty)
  );

  // Table engine.
  ftt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (fq_empty),
    .q_pop    (fq_pop),
    .q_data   (fq_rdata),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .clearing (clearing),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

// ----- rtl/ftt_checker.sv -----
// Port-level checks of the flow table tracker, bound to its top level.
module ftt_checker (
  input logic             clk,
  input logic             rst,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input ftt_pkg::result_t result
);
  import ftt_pkg::*;

  // The clearing pass keeps the input closed right after reset.
  a_full_after_reset: assert property (@(posedge clk) rst |=> full)
    else $error("input open right after reset");

  // No result is shown right after reset.
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // A waiting result holds until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");

  // A new session reports from_client and an empty snapshot.
  a_new_snapshot: assert property (@(posedge clk) disable iff (rst)
    !empty && result.status == ST_NEW |->
      result.from_client && result.pkts_out_before == 32'd0 &&
      result.pkts_in_before == 32'd0 && result.last_seen_before == 32'd0)
    else $error("new session with nonzero snapshot");

  // Only ignored results carry a removal count.
  a_removed_only_sweep: assert property (@(posedge clk) disable iff (rst)
    !empty && result.status != ST_IGNORED |-> result.removed_count == 11'd0)
    else $error("removal count on a packet result");

endmodule

bind flow_table_tcp_state_tracker_top ftt_checker u_chk (.*);
